/* hw/rtl/rmq_pkg.sv */
package rmq_pkg;

    // Table geometry
    localparam int NUM_ENTRIES = 1024;
    localparam int SCORE_BITS  = 16;

    // Fixed field widths
    localparam int ID_W    = 11;
    localparam int FIELD_W = 16;

    // Chain layout: entry e lives in cell e % NUM_CELLS at slot e / NUM_CELLS
    localparam int NUM_CELLS  = 32;
    localparam int CELL_IDX_W = $clog2(NUM_CELLS);
    localparam int CELL_DEPTH = (NUM_ENTRIES + NUM_CELLS - 1) / NUM_CELLS;
    localparam int CELL_AW    = (CELL_DEPTH > 1) ? $clog2(CELL_DEPTH) : 1;
    localparam int CELL_SLOTS = 2 ** CELL_AW;
    localparam int ENTRY_W    = (CELL_AW + CELL_IDX_W > ID_W) ? CELL_AW + CELL_IDX_W : ID_W;

    // Query sweep: CELL_DEPTH reads, then the maximum ripples down the chain
    localparam int RUN_LAST = CELL_DEPTH + NUM_CELLS - 1;
    localparam int STEP_W   = $clog2(RUN_LAST + 1);

    localparam logic OP_QUERY      = 1'b0;
    localparam logic OP_UPDATE     = 1'b1;
    localparam logic STATUS_OK     = 1'b0;
    localparam logic STATUS_BAD_ID = 1'b1;

    typedef logic [SCORE_BITS-1:0] t_score;

    typedef struct packed {
        logic                  wr_en;
        logic                  wr_all;
        logic [CELL_IDX_W-1:0] wr_cell;
        logic [CELL_AW-1:0]    wr_addr;
        t_score                wr_data;
        logic                  rd_en;
        logic [CELL_AW-1:0]    rd_addr;
        logic [ENTRY_W-1:0]    lo;
        logic [ENTRY_W-1:0]    hi;
        logic                  acc_clr;
    } t_cell_ctl;

    function automatic t_score score_from_field(input logic [FIELD_W-1:0] f);
        logic [31:0] w;
        w = 32'(f);
        return w[SCORE_BITS-1:0];
    endfunction

    function automatic logic [FIELD_W-1:0] score_to_field(input t_score s);
        logic [31:0] w;
        w = 32'(s);
        return w[FIELD_W-1:0];
    endfunction

endpackage

/* hw/rtl/rmq_req_if.sv */
interface rmq_req_if import rmq_pkg::*; ();
    logic               valid;
    logic               ready;
    logic               operation;
    logic [ID_W-1:0]    first_id;
    logic [ID_W-1:0]    second_id;
    logic [FIELD_W-1:0] new_score;

    modport source (output valid, operation, first_id, second_id, new_score, input ready);
    modport sink   (input valid, operation, first_id, second_id, new_score, output ready);
endinterface

/* hw/rtl/rmq_rsp_if.sv */
interface rmq_rsp_if import rmq_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [FIELD_W-1:0] max_score;
    logic               status;

    modport source (output valid, max_score, status, input ready);
    modport sink   (input valid, max_score, status, output ready);
endinterface

/* hw/rtl/rmq_cell.sv */
module rmq_cell import rmq_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_cell_ctl             i_ctl,
    input  logic [CELL_IDX_W-1:0] i_cell_idx,
    input  t_score                i_left_max,
    output t_score                o_max
);

    t_score             r_mem [CELL_SLOTS];
    t_score             r_rd_data;
    logic               r_hit;
    t_score             r_acc;
    t_score             n_acc;
    logic [ENTRY_W-1:0] w_entry;
    t_score             w_rd_val;

    assign w_entry = ENTRY_W'({i_ctl.rd_addr, i_cell_idx});

    always_ff @(posedge i_clk) begin
        if (i_ctl.wr_en && (i_ctl.wr_all || (i_ctl.wr_cell == i_cell_idx))) begin
            r_mem[i_ctl.wr_addr] <= i_ctl.wr_data;
        end
        r_rd_data <= r_mem[i_ctl.rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hit <= 1'b0;
        end else begin
            r_hit <= i_ctl.rd_en && (w_entry >= i_ctl.lo) && (w_entry <= i_ctl.hi);
        end
    end

    // Fold the local read and the neighbor's running maximum into the accumulator; acc_clr empties it
    always_comb begin
        w_rd_val = r_hit ? r_rd_data : '0;
        n_acc    = r_acc;
        if (i_left_max > n_acc) n_acc = i_left_max;
        if (w_rd_val > n_acc) n_acc = w_rd_val;
        if (i_ctl.acc_clr) n_acc = '0;
    end

    always_ff @(posedge i_clk) begin
        r_acc <= n_acc;
    end

    assign o_max = r_acc;

endmodule

/* hw/rtl/range_max_query_with_point_update_unit.sv */
// Update: accepted with no result; the next request may follow at once.
// Query: the result is registered once the sweep is over and the output register is free:
//   CELL_DEPTH slot reads in every cell, then the maximum ripples down the
//   cell chain; one query at a time, with ready low until the result is handed over.
// Query with an id out of range: no sweep; the result is loaded from ST_DONE.
// Reset: synchronous, active low; a clearing pass then zeroes the table with
//   ready held low.
module range_max_query_with_point_update_unit import rmq_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    rmq_req_if.sink   i_req,
    rmq_rsp_if.source o_rsp
);

    localparam logic [1:0] ST_CLR  = 2'd0;
    localparam logic [1:0] ST_IDLE = 2'd1;
    localparam logic [1:0] ST_RUN  = 2'd2;
    localparam logic [1:0] ST_DONE = 2'd3;

    logic [1:0]         r_state;
    logic [1:0]         n_state;
    logic [CELL_AW-1:0] r_clr;
    logic [STEP_W-1:0]  r_step;
    logic [ENTRY_W-1:0] r_lo;
    logic [ENTRY_W-1:0] r_hi;
    logic               r_bad;
    logic               r_out_valid;
    logic [FIELD_W-1:0] r_out_score;
    logic               r_out_status;

    logic               w_accept;
    logic               w_first_ok;
    logic               w_second_ok;
    logic               w_swap;
    logic [ID_W-1:0]    w_lo_id;
    logic [ID_W-1:0]    w_hi_id;
    logic [ENTRY_W-1:0] w_upd_entry;
    logic               w_load;
    t_cell_ctl          w_ctl;
    t_score             w_chain [NUM_CELLS+1];

    // ---------------------------------------------------------------------
    // Request decode
    // ---------------------------------------------------------------------
    assign i_req.ready = (r_state == ST_IDLE);
    assign w_accept    = i_req.valid && i_req.ready;

    // An id is good when it names an entry: 1..NUM_ENTRIES
    assign w_first_ok  = (i_req.first_id != '0) &&
                         (32'(i_req.first_id) <= 32'(NUM_ENTRIES));
    assign w_second_ok = (i_req.second_id != '0) &&
                         (32'(i_req.second_id) <= 32'(NUM_ENTRIES));

    // Order the query ids so the range runs low to high
    assign w_swap  = i_req.first_id > i_req.second_id;
    assign w_lo_id = w_swap ? i_req.second_id : i_req.first_id;
    assign w_hi_id = w_swap ? i_req.first_id  : i_req.second_id;

    // Zero-based entry of an update; the low bits pick the cell
    assign w_upd_entry = ENTRY_W'(i_req.first_id - ID_W'(1));

    // ---------------------------------------------------------------------
    // Cell control: clearing pass, point writes and the query sweep
    // ---------------------------------------------------------------------
    always_comb begin
        w_ctl         = '0;
        w_ctl.lo      = r_lo;
        w_ctl.hi      = r_hi;
        w_ctl.rd_addr = r_step[CELL_AW-1:0];
        w_ctl.rd_en   = (r_state == ST_RUN) && (32'(r_step) < 32'(CELL_DEPTH));
        if (r_state == ST_CLR) begin
            // Zero one slot of every cell per cycle
            w_ctl.wr_en   = 1'b1;
            w_ctl.wr_all  = 1'b1;
            w_ctl.wr_addr = r_clr;
        end else if (w_accept && (i_req.operation == OP_UPDATE)) begin
            // Drop updates that name no entry
            w_ctl.wr_en   = w_first_ok;
            w_ctl.wr_cell = w_upd_entry[CELL_IDX_W-1:0];
            w_ctl.wr_addr = w_upd_entry[CELL_AW+CELL_IDX_W-1:CELL_IDX_W];
            w_ctl.wr_data = score_from_field(i_req.new_score);
        end
        // Start every query from an empty maximum in all cells
        w_ctl.acc_clr = w_accept && (i_req.operation == OP_QUERY);
    end

    // ---------------------------------------------------------------------
    // The cell chain: the running maximum advances one cell per cycle
    // ---------------------------------------------------------------------
    assign w_chain[0] = '0;

    for (genvar g = 0; g < NUM_CELLS; g++) begin : g_cell
        rmq_cell u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_ctl      (w_ctl),
            .i_cell_idx (CELL_IDX_W'(g)),
            .i_left_max (w_chain[g]),
            .o_max      (w_chain[g+1])
        );
    end

    // ---------------------------------------------------------------------
    // Sequencer
    // ---------------------------------------------------------------------
    // Hand the result over once the output register is free
    assign w_load = (r_state == ST_DONE) && (!r_out_valid || o_rsp.ready);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_CLR: begin
                if (r_clr == '1) n_state = ST_IDLE;
            end
            ST_IDLE: begin
                if (w_accept && (i_req.operation == OP_QUERY)) begin
                    n_state = (w_first_ok && w_second_ok) ? ST_RUN : ST_DONE;
                end
            end
            ST_RUN: begin
                if (32'(r_step) == 32'(RUN_LAST)) n_state = ST_DONE;
            end
            ST_DONE: begin
                if (w_load) n_state = ST_IDLE;
            end
            default: n_state = ST_CLR;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLR;
            r_clr       <= '0;
            r_step      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= w_load || (r_out_valid && !o_rsp.ready);
            if (r_state == ST_CLR) r_clr <= r_clr + CELL_AW'(1);
            if (r_state == ST_RUN) begin
                r_step <= r_step + STEP_W'(1);
            end else begin
                r_step <= '0;
            end
        end
    end

    // Hold the query range and error flag for the whole sweep
    always_ff @(posedge i_clk) begin
        if (w_accept && (i_req.operation == OP_QUERY)) begin
            r_lo  <= ENTRY_W'(w_lo_id - ID_W'(1));
            r_hi  <= ENTRY_W'(w_hi_id - ID_W'(1));
            r_bad <= !(w_first_ok && w_second_ok);
        end
        if (w_load) begin
            r_out_score  <= r_bad ? '0 : score_to_field(w_chain[NUM_CELLS]);
            r_out_status <= r_bad ? STATUS_BAD_ID : STATUS_OK;
        end
    end

    assign o_rsp.valid     = r_out_valid;
    assign o_rsp.max_score = r_out_score;
    assign o_rsp.status    = r_out_status;

    // ---------------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------------
    a_update_no_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && (i_req.operation == OP_UPDATE) && !r_out_valid) |=> !o_rsp.valid)
        else $error("update produced a result");

    a_query_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && (i_req.operation == OP_QUERY)) |=>
        ((r_state == ST_RUN) || (r_state == ST_DONE)))
        else $error("query did not start");

    a_range_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == ST_RUN) && $past(r_state == ST_RUN)) |->
        ($stable(r_lo) && $stable(r_hi)))
        else $error("query range changed during sweep");

endmodule
